FILE: sv/pdpi_pkg.sv
// shared types, widths and constants for the pps disciplined pi duty unit
package pdpi_pkg;

	localparam int CAP_W       = 16;
	localparam int DUTY_W      = 10;
	localparam int GAIN_W      = 8;
	localparam int LIM_W       = 15;
	localparam int SETTLE_W    = 4;
	localparam int CENTER_W    = DUTY_W;
	localparam int ERR_W       = CAP_W + 1;
	localparam int CMD_W       = LIM_W + 1;
	localparam int SCL_W       = 10;
	localparam int PHASE_W     = 2;

	localparam int SCALE_DIV   = 100;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP       = (1 << RECIP_SHIFT) / SCALE_DIV + 1;
	localparam int RECIP_W     = 15;
	localparam int MAG_W       = CMD_W - 1;
	localparam int QUO_W       = 9;

	localparam int ADDR_W      = 5;
	localparam int APB_W       = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	localparam logic [GAIN_W-1:0]   PROP_RST   = GAIN_W'(29);
	localparam logic [GAIN_W-1:0]   INTEG_RST  = GAIN_W'(25);
	localparam logic [LIM_W-1:0]    LIMIT_RST  = LIM_W'(5000);
	localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(10);
	localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(512);

	typedef enum logic [2:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_INTEGRAL_GAIN = 3'd1,
		REG_COMMAND_LIMIT = 3'd2,
		REG_SETTLE_COUNT  = 3'd3,
		REG_DUTY_CENTER   = 3'd4
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_SETTLE = 2'd0,
		PH_LATCH  = 2'd1,
		PH_CTRL   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integral_gain;
		logic [LIM_W-1:0]    command_limit;
		logic [SETTLE_W-1:0] settle_count;
		logic [CENTER_W-1:0] duty_center;
	} cfg_t;

	typedef struct packed {
		phase_t                   phase;
		logic signed [ERR_W-1:0]  error_value;
		logic signed [CMD_W-1:0]  command;
	} ctrl_res_t;

endpackage

FILE: sv/pdpi_ctrl.sv
// control update stage: settle, setpoint latch and velocity-form pi command
module pdpi_ctrl
	import pdpi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CAP_W-1:0] capture,
	output logic             out_valid,
	input  logic             out_ready,
	output ctrl_res_t        res
);

	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = DIFF_W + GAIN_W + 1;
	localparam int IP_W   = ERR_W + GAIN_W + 1;
	localparam int SUM_W  = PP_W + 1;

	logic [SETTLE_W-1:0]     settle_counter_q;
	logic                    taken_q;
	logic [CAP_W-1:0]        setpoint_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [CMD_W-1:0] command_q;
	logic                    v_s2;
	ctrl_res_t               res_s2;

	logic                    adv;
	logic signed [ERR_W-1:0] err;
	logic signed [DIFF_W-1:0] diff;
	logic signed [GAIN_W:0]  kp_s;
	logic signed [GAIN_W:0]  ki_s;
	logic signed [PP_W-1:0]  p_prod;
	logic signed [IP_W-1:0]  i_prod;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim_pos;
	logic signed [SUM_W-1:0] lim_neg;
	logic signed [CMD_W-1:0] cmd_next;

	assign in_ready  = !v_s2 || out_ready;
	assign adv       = in_valid && in_ready;
	assign out_valid = v_s2;
	assign res       = res_s2;

	always_comb begin
		err     = $signed({1'b0, setpoint_q}) - $signed({1'b0, capture});
		diff    = DIFF_W'(err) - DIFF_W'(prev_err_q);
		kp_s    = $signed({1'b0, cfg.prop_gain});
		ki_s    = $signed({1'b0, cfg.integral_gain});
		p_prod  = kp_s * diff;
		i_prod  = ki_s * err;
		sum     = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(command_q);
		lim_pos = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.command_limit});
		lim_neg = -lim_pos;
		if (sum < lim_neg) begin
			cmd_next = CMD_W'(lim_neg);
		end else if (sum > lim_pos) begin
			cmd_next = CMD_W'(lim_pos);
		end else begin
			cmd_next = CMD_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_counter_q <= '0;
			taken_q          <= 1'b0;
			setpoint_q       <= '0;
			prev_err_q       <= '0;
			command_q        <= '0;
			v_s2             <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (adv) begin
				if (!taken_q) begin
					if (settle_counter_q < cfg.settle_count) begin
						settle_counter_q <= settle_counter_q + SETTLE_W'(1);
					end else begin
						taken_q    <= 1'b1;
						setpoint_q <= capture;
					end
				end else begin
					command_q  <= cmd_next;
					prev_err_q <= err;
				end
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!taken_q) begin
				res_s2.phase       <= (settle_counter_q < cfg.settle_count) ? PH_SETTLE
				                                                            : PH_LATCH;
				res_s2.error_value <= '0;
				res_s2.command     <= command_q;
			end else begin
				res_s2.phase       <= PH_CTRL;
				res_s2.error_value <= err;
				res_s2.command     <= cmd_next;
			end
		end
	end

	a_taken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q |=> taken_q)
		else $error("setpoint latch flag dropped");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res_s2.phase != PH_CTRL) |-> (res_s2.error_value == '0))
		else $error("nonzero error outside control phase");

	a_cmd_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.command == command_q))
		else $error("reported command differs from held command");

endmodule

FILE: sv/pdpi_out.sv
// output stage: command divided by 100 toward zero, duty saturation, result register
module pdpi_out
	import pdpi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CENTER_W-1:0]    duty_center,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ctrl_res_t              res,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int DSUM_W = DUTY_W + 2;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
	localparam logic signed [DSUM_W-1:0] DUTY_MAX = DSUM_W'((1 << DUTY_W) - 1);

	logic                     neg;
	logic [CMD_W-1:0]         mag_full;
	logic [MAG_W-1:0]         mag;
	logic [PROD_W-1:0]        prod;
	logic [QUO_W-1:0]         quo;
	logic signed [SCL_W-1:0]  scaled;
	logic signed [DSUM_W-1:0] dsum;
	logic [DUTY_W-1:0]        duty;
	logic                     adv;

	assign in_ready = !m_tvalid || m_tready;
	assign adv      = in_valid && in_ready;

	always_comb begin
		neg      = res.command[CMD_W-1];
		mag_full = neg ? CMD_W'(-res.command) : CMD_W'(res.command);
		mag      = mag_full[MAG_W-1:0];
		// reciprocal multiply, exact for every magnitude below 2^15
		prod     = PROD_W'(mag) * PROD_W'(RECIP_K);
		quo      = prod[RECIP_SHIFT +: QUO_W];
		scaled   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		dsum     = $signed({2'b00, duty_center}) + DSUM_W'(scaled);
		if (dsum < 0) begin
			duty = '0;
		end else if (dsum > DUTY_MAX) begin
			duty = DUTY_MAX[DUTY_W-1:0];
		end else begin
			duty = dsum[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_ready) begin
			m_tvalid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {1'b0, scaled, res.error_value, duty, res.phase};
		end
	end

	a_zero_cmd_center: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.command == '0) |=> (m_tdata[PHASE_W +: DUTY_W] == $past(duty_center)))
		else $error("zero command did not give center duty");

	a_sign_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (!scaled[SCL_W-1] || neg))
		else $error("scaled command sign disagrees with command");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[OUT_TDATA_W-1])
		else $error("result padding bit set");

endmodule

FILE: sv/pps_disciplined_pi_duty_unit.sv
// top level of the pps disciplined pi duty unit: config registers, input stage, pipeline
// pipeline: a capture passes the input register, the control update register and then
//   the output register before its result is valid on the master side
// throughput: one capture per cycle unless stalled; command feedback closes in control stage
// each stage holds while its successor is full and stalled, so results are never dropped
// reset: arst_n clears the stage valids and pi state, config registers return to defaults
module pps_disciplined_pi_duty_unit
	import pdpi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// capture stream in
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] capture_count
	// result stream out
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] phase, [11:2] duty, [28:12] error_value, [38:29] command_scaled, [39] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// register port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_W-1:0]       pwdata,
	output logic [APB_W-1:0]       prdata,
	output logic                   pready
);

	cfg_t             cfg_q;
	logic             v_s1;
	logic [CAP_W-1:0] cap_s1;
	logic             ctrl_ready;
	logic             ctrl_valid;
	logic             out_ready;
	ctrl_res_t        ctrl_res;
	logic             wr_en;
	reg_idx_t         widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[4:2]);

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= PROP_RST;
			cfg_q.integral_gain <= INTEG_RST;
			cfg_q.command_limit <= LIMIT_RST;
			cfg_q.settle_count  <= SETTLE_RST;
			cfg_q.duty_center   <= CENTER_RST;
		end else if (wr_en) begin
			case (widx)
				REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[GAIN_W-1:0];
				REG_INTEGRAL_GAIN: cfg_q.integral_gain <= pwdata[GAIN_W-1:0];
				REG_COMMAND_LIMIT: cfg_q.command_limit <= pwdata[LIM_W-1:0];
				REG_SETTLE_COUNT:  cfg_q.settle_count  <= pwdata[SETTLE_W-1:0];
				REG_DUTY_CENTER:   cfg_q.duty_center   <= pwdata[CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (widx)
			REG_PROP_GAIN:     prdata = APB_W'(cfg_q.prop_gain);
			REG_INTEGRAL_GAIN: prdata = APB_W'(cfg_q.integral_gain);
			REG_COMMAND_LIMIT: prdata = APB_W'(cfg_q.command_limit);
			REG_SETTLE_COUNT:  prdata = APB_W'(cfg_q.settle_count);
			REG_DUTY_CENTER:   prdata = APB_W'(cfg_q.duty_center);
			default:           prdata = '0;
		endcase
	end

	// input register, refills whenever the control stage takes its item
	assign s_tready = !v_s1 || ctrl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cap_s1 <= s_tdata[CAP_W-1:0];
		end
	end

	// settle count, setpoint latch and pi command update
	pdpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v_s1),
		.in_ready  (ctrl_ready),
		.capture   (cap_s1),
		.out_valid (ctrl_valid),
		.out_ready (out_ready),
		.res       (ctrl_res)
	);

	// scaling, duty clamp and result register
	pdpi_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.duty_center (cfg_q.duty_center),
		.in_valid    (ctrl_valid),
		.in_ready    (out_ready),
		.res         (ctrl_res),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ctrl_ready) |=> (v_s1 && $stable(cap_s1)))
		else $error("input stage lost a stalled capture");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && widx == REG_SETTLE_COUNT) |=> (cfg_q.settle_count == $past(pwdata[SETTLE_W-1:0])))
		else $error("settle count write not taken");

	a_ready_path: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1) |-> s_tready)
		else $error("empty input stage refused a transaction");

endmodule
